@@ rtl/core/slt_pkg.sv @@
// Package for the script lexer tokenizer: scan modes, token kind codes,
// byte classes and the keyword table.
// No dependencies.
package slt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_COMMENT,
    MODE_ERROR
  } scan_mode_t;

  localparam int NUM_KW = 10;

  typedef logic [NUM_KW-1:0] kw_mask_t;
  typedef logic [4:0]        kind_t;
  typedef logic [7:0]        char_t;

  localparam kind_t KIND_IDENT     = 5'd0;
  localparam kind_t KIND_NUMBER    = 5'd1;
  localparam kind_t KIND_STRING    = 5'd2;
  localparam kind_t KIND_KW_FIRST  = 5'd3;
  localparam kind_t KIND_SYM_FIRST = 5'd13;
  localparam kind_t KIND_EOF       = 5'd26;
  localparam kind_t KIND_BAD       = 5'd27;
  localparam kind_t KIND_UNTERM    = 5'd28;

  localparam char_t CHAR_TAB     = 8'h09;
  localparam char_t CHAR_CR      = 8'h0D;
  localparam char_t CHAR_NEWLINE = 8'h0A;
  localparam char_t CHAR_SPACE   = 8'h20;
  localparam char_t CHAR_QUOTE   = 8'h22;
  localparam char_t CHAR_HASH    = 8'h23;
  localparam char_t CHAR_UNDER   = 8'h5F;

  function automatic logic is_alpha(char_t b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_digit(char_t b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_space(char_t b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  // Returns the symbol's kind code, or KIND_BAD when the byte is no symbol.
  function automatic kind_t sym_kind(char_t b);
    kind_t k;
    case (b)
      8'h3D:   k = KIND_SYM_FIRST + 5'd0;
      8'h28:   k = KIND_SYM_FIRST + 5'd1;
      8'h29:   k = KIND_SYM_FIRST + 5'd2;
      8'h7B:   k = KIND_SYM_FIRST + 5'd3;
      8'h7D:   k = KIND_SYM_FIRST + 5'd4;
      8'h5B:   k = KIND_SYM_FIRST + 5'd5;
      8'h5D:   k = KIND_SYM_FIRST + 5'd6;
      8'h2B:   k = KIND_SYM_FIRST + 5'd7;
      8'h2D:   k = KIND_SYM_FIRST + 5'd8;
      8'h2F:   k = KIND_SYM_FIRST + 5'd9;
      8'h2A:   k = KIND_SYM_FIRST + 5'd10;
      8'h2E:   k = KIND_SYM_FIRST + 5'd11;
      8'h2C:   k = KIND_SYM_FIRST + 5'd12;
      default: k = KIND_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] kw_len(logic [3:0] idx);
    logic [2:0] l;
    case (idx)
      4'd0:    l = 3'd3;
      4'd1:    l = 3'd2;
      4'd2:    l = 3'd4;
      4'd3:    l = 3'd2;
      4'd4:    l = 3'd4;
      4'd5:    l = 3'd4;
      4'd6:    l = 3'd5;
      4'd7:    l = 3'd4;
      4'd8:    l = 3'd3;
      default: l = 3'd2;
    endcase
    return l;
  endfunction

  // Keyword text, left aligned in five bytes.
  function automatic logic [39:0] kw_text(logic [3:0] idx);
    logic [39:0] t;
    case (idx)
      4'd0:    t = {"Cmd", 16'h0};
      4'd1:    t = {"fn", 24'h0};
      4'd2:    t = {"File", 8'h0};
      4'd3:    t = {"if", 24'h0};
      4'd4:    t = {"else", 8'h0};
      4'd5:    t = {"elif", 8'h0};
      4'd6:    t = "while";
      4'd7:    t = {"loop", 8'h0};
      4'd8:    t = {"for", 16'h0};
      default: t = {"in", 24'h0};
    endcase
    return t;
  endfunction

  function automatic char_t kw_char(logic [3:0] idx, logic [2:0] pos);
    logic [39:0] t;
    char_t       c;
    t = kw_text(idx);
    case (pos)
      3'd0:    c = t[39:32];
      3'd1:    c = t[31:24];
      3'd2:    c = t[23:16];
      3'd3:    c = t[15:8];
      3'd4:    c = t[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Drops every keyword that cannot match once byte b lands at position pos.
  // pos_ok is low when the token is already too long for pos to hold its position.
  function automatic kw_mask_t kw_narrow(kw_mask_t cand, logic [2:0] pos, logic pos_ok,
                                         char_t b);
    kw_mask_t m;
    m = cand;
    for (int i = 0; i < NUM_KW; i++) begin
      if (!pos_ok || (pos >= kw_len(4'(i))) || (kw_char(4'(i), pos) != b)) begin
        m[i] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic kind_t kw_kind(kw_mask_t cand, logic [2:0] len, logic len_ok);
    kind_t k;
    k = KIND_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (cand[i] && len_ok && (len == kw_len(4'(i)))) begin
        k = KIND_KW_FIRST + 5'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ rtl/core/script_lexer_tokenizer_core.sv @@
// Top level of the script lexer tokenizer: scan state registers and a
// four-entry result queue. Depends on slt_pkg.
//
// Usage: each input request carries one source byte (in_cmd low) or an
// end-of-input marker (in_cmd high). Each input request yields zero, one or
// two token results on the output channel; out_last_result marks the final
// result of that input request. Tokens carry a kind code, the start offset
// and the length of their text.
// Results: the results of an accepted input request are registered in the
// result queue and reach the output behind any results queued before them.
// Throughput: one input request per cycle while in_ready is high, as the scan
// state is updated from each incoming byte. Results leave at one per cycle
// while out_ready is high, so the two results of one request leave in turn.
// Stall: results wait in a four-entry queue; in_ready drops while fewer than
// two entries are free and returns as the receiver takes results.
// Reset: the queue empties, the scanner is idle and the stream offset is
// zero. An end-of-input request restores that same scan state.
module script_lexer_tokenizer_core #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [7:0]             in_char_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output slt_pkg::kind_t         out_token_kind,
  output logic [OFFSET_BITS-1:0] out_text_start,
  output logic [OFFSET_BITS-1:0] out_text_length,
  output logic                   out_last_result
);
  import slt_pkg::*;

  typedef logic [OFFSET_BITS-1:0] off_t;

  localparam int QDEPTH = 4;

  function automatic off_t sat_inc(off_t v);
    return (v == '1) ? v : v + off_t'(1);
  endfunction

  scan_mode_t mode_r, mode_nxt;
  kw_mask_t   cand_r, cand_nxt;
  off_t       begin_r, begin_nxt;
  off_t       tok_len_r, tok_len_nxt;
  off_t       offset_r, offset_nxt;

  kind_t      q_kind_r  [QDEPTH];
  off_t       q_start_r [QDEPTH];
  off_t       q_len_r   [QDEPTH];
  logic       q_last_r  [QDEPTH];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [2:0] fill_r, fill_nxt;

  logic accept;
  logic pop;
  logic id_char;
  logic pos_ok;
  kind_t flush_kind;
  kind_t sym_k;

  scan_mode_t st_mode;
  kw_mask_t   st_cand;
  off_t       st_begin;
  off_t       st_len;
  logic       st_emit;
  kind_t      st_kind;
  off_t       st_tlen;

  logic  a_v, b_v;
  kind_t a_kind, b_kind;
  off_t  a_start, b_start, a_len, b_len;

  logic [1:0] push_n;
  kind_t      e0_kind;
  off_t       e0_start, e0_len;
  logic       e0_last;

  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = (fill_r <= 3'd2);
  assign out_valid = (fill_r != 3'd0);

  assign out_token_kind  = q_kind_r[head_r];
  assign out_text_start  = q_start_r[head_r];
  assign out_text_length = q_len_r[head_r];
  assign out_last_result = q_last_r[head_r];

  assign id_char    = is_alpha(in_char_byte) || is_digit(in_char_byte) ||
                      (in_char_byte == CHAR_UNDER);
  assign pos_ok     = ((tok_len_r >> 3) == off_t'(0));
  assign flush_kind = (mode_r == MODE_IDENT) ? kw_kind(cand_r, tok_len_r[2:0], pos_ok)
                                             : KIND_NUMBER;
  assign sym_k      = sym_kind(in_char_byte);

  // Scan of a byte that arrives with no token in progress.
  always_comb begin
    st_mode  = MODE_IDLE;
    st_cand  = cand_r;
    st_begin = begin_r;
    st_len   = tok_len_r;
    st_emit  = 1'b0;
    st_kind  = KIND_BAD;
    st_tlen  = '0;
    if (is_space(in_char_byte)) begin
      st_mode = MODE_IDLE;
    end else if (is_alpha(in_char_byte) || (in_char_byte == CHAR_UNDER)) begin
      st_mode  = MODE_IDENT;
      st_begin = offset_r;
      st_len   = off_t'(1);
      st_cand  = kw_narrow('1, 3'd0, 1'b1, in_char_byte);
    end else if (is_digit(in_char_byte)) begin
      st_mode  = MODE_NUMBER;
      st_begin = offset_r;
      st_len   = off_t'(1);
    end else if (in_char_byte == CHAR_QUOTE) begin
      st_mode  = MODE_STRING;
      st_begin = sat_inc(offset_r);
      st_len   = '0;
    end else if (sym_k != KIND_BAD) begin
      st_emit = 1'b1;
      st_kind = sym_k;
      st_tlen = off_t'(1);
    end else if (in_char_byte == CHAR_HASH) begin
      st_mode = MODE_COMMENT;
    end else begin
      st_emit = 1'b1;
      st_kind = KIND_BAD;
      st_mode = MODE_ERROR;
    end
  end

  // Next scan state and the results of the current request. Result A is a
  // flushed token, result B anything that follows it.
  always_comb begin
    mode_nxt    = mode_r;
    cand_nxt    = cand_r;
    begin_nxt   = begin_r;
    tok_len_nxt = tok_len_r;
    offset_nxt  = offset_r;
    a_v         = 1'b0;
    a_kind      = flush_kind;
    a_start     = begin_r;
    a_len       = tok_len_r;
    b_v         = 1'b0;
    b_kind      = st_kind;
    b_start     = offset_r;
    b_len       = st_tlen;
    if (in_cmd) begin
      mode_nxt    = MODE_IDLE;
      cand_nxt    = '1;
      begin_nxt   = '0;
      tok_len_nxt = '0;
      offset_nxt  = '0;
      if (mode_r == MODE_STRING) begin
        b_v     = 1'b1;
        b_kind  = KIND_UNTERM;
        b_start = begin_r;
        b_len   = '0;
      end else if (mode_r != MODE_ERROR) begin
        a_v     = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER);
        b_v     = 1'b1;
        b_kind  = KIND_EOF;
        b_start = offset_r;
        b_len   = '0;
      end
    end else begin
      offset_nxt = sat_inc(offset_r);
      unique case (mode_r)
        MODE_IDENT, MODE_NUMBER: begin
          if ((mode_r == MODE_IDENT) && id_char) begin
            cand_nxt    = kw_narrow(cand_r, tok_len_r[2:0], pos_ok, in_char_byte);
            tok_len_nxt = sat_inc(tok_len_r);
          end else if ((mode_r == MODE_NUMBER) && is_digit(in_char_byte)) begin
            tok_len_nxt = sat_inc(tok_len_r);
          end else begin
            a_v         = 1'b1;
            b_v         = st_emit;
            mode_nxt    = st_mode;
            cand_nxt    = st_cand;
            begin_nxt   = st_begin;
            tok_len_nxt = st_len;
          end
        end
        MODE_STRING: begin
          if (in_char_byte == CHAR_QUOTE) begin
            b_v      = 1'b1;
            b_kind   = KIND_STRING;
            b_start  = begin_r;
            b_len    = tok_len_r;
            mode_nxt = MODE_IDLE;
          end else begin
            tok_len_nxt = sat_inc(tok_len_r);
          end
        end
        MODE_COMMENT: begin
          if (in_char_byte == CHAR_NEWLINE) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_ERROR: begin
          mode_nxt = MODE_ERROR;
        end
        default: begin
          b_v         = st_emit;
          mode_nxt    = st_mode;
          cand_nxt    = st_cand;
          begin_nxt   = st_begin;
          tok_len_nxt = st_len;
        end
      endcase
    end
  end

  always_comb begin
    push_n   = accept ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    e0_kind  = a_v ? a_kind : b_kind;
    e0_start = a_v ? a_start : b_start;
    e0_len   = a_v ? a_len : b_len;
    e0_last  = !(a_v && b_v);
    head_nxt = pop ? head_r + 2'd1 : head_r;
    tail_nxt = tail_r + push_n;
    fill_nxt = fill_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      cand_r    <= '1;
      begin_r   <= '0;
      tok_len_r <= '0;
      offset_r  <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
    end else begin
      if (accept) begin
        mode_r    <= mode_nxt;
        cand_r    <= cand_nxt;
        begin_r   <= begin_nxt;
        tok_len_r <= tok_len_nxt;
        offset_r  <= offset_nxt;
      end
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_kind_r[tail_r]  <= e0_kind;
      q_start_r[tail_r] <= e0_start;
      q_len_r[tail_r]   <= e0_len;
      q_last_r[tail_r]  <= e0_last;
    end
    if (push_n == 2'd2) begin
      q_kind_r[tail_r + 2'd1]  <= b_kind;
      q_start_r[tail_r + 2'd1] <= b_start;
      q_len_r[tail_r + 2'd1]   <= b_len;
      q_last_r[tail_r + 2'd1]  <= 1'b1;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'd4)
    else $error("result queue overfilled");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd |=> (mode_r == MODE_IDLE) && (offset_r == '0))
    else $error("end of input did not restore the scan state");

  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (mode_r == MODE_ERROR) && !in_cmd
      |=> fill_r == $past(fill_r) - {2'b00, $past(pop)})
    else $error("result produced in error mode");

  a_queue_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 3'd0) || (fill_r == 3'd4) |-> head_r == tail_r)
    else $error("queue pointers disagree with fill count");
`endif

endmodule

@@ bench/lexer_token_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the script lexer tokenizer: follows every accepted input
// request with its own scanner, queues the tokens that request should yield
// and compares them with the tokens delivered. Depends on slt_pkg.
module lexer_token_checker #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [7:0]             in_char_byte,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  slt_pkg::kind_t         out_token_kind,
  input  logic [OFFSET_BITS-1:0] out_text_start,
  input  logic [OFFSET_BITS-1:0] out_text_length,
  input  logic                   out_last_result,
  output int                     fail_count,
  output int                     pending
);
  import slt_pkg::*;

  localparam logic CMD_END = 1'b1;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
  localparam logic [9:0] ALL_WORDS = '1;

  typedef struct packed {
    kind_t                  kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] length;
    logic                   last;
  } token_t;

  string kw_words [10] = '{"Cmd", "fn", "File", "if", "else", "elif", "while", "loop",
                           "for", "in"};
  string sym_chars = "=(){}[]+-/*.,";

  scan_mode_t             mode;
  logic [9:0]             word_match;
  logic [OFFSET_BITS-1:0] tok_begin;
  logic [OFFSET_BITS-1:0] tok_count;
  logic [OFFSET_BITS-1:0] offset;
  token_t                 fresh [$];
  token_t                 tokens_due [$];

  function automatic logic [OFFSET_BITS-1:0] bump(logic [OFFSET_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic letter_byte(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic digit_byte(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic blank_byte(logic [7:0] b);
    return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  task automatic clear_scan();
    mode = MODE_IDLE;
    word_match = ALL_WORDS;
    tok_begin = '0;
    tok_count = '0;
    offset = '0;
  endtask

  task automatic add_token(kind_t k, logic [OFFSET_BITS-1:0] s, logic [OFFSET_BITS-1:0] l);
    token_t t;
    t.kind = k;
    t.start = s;
    t.length = l;
    t.last = 1'b0;
    fresh.push_back(t);
  endtask

  task automatic narrow(logic [7:0] b);
    for (int i = 0; i < 10; i++) begin
      if (word_match[i]) begin
        if (tok_count >= kw_words[i].len() || kw_words[i][int'(tok_count)] != b) begin
          word_match[i] = 1'b0;
        end
      end
    end
  endtask

  task automatic flush_word();
    kind_t k;
    k = KIND_IDENT;
    if (mode == MODE_IDENT) begin
      for (int i = 0; i < 10; i++) begin
        if (word_match[i] && tok_count == kw_words[i].len()) begin
          k = kind_t'(KIND_KW_FIRST + i);
        end
      end
      add_token(k, tok_begin, tok_count);
    end else if (mode == MODE_NUMBER) begin
      add_token(KIND_NUMBER, tok_begin, tok_count);
    end
    mode = MODE_IDLE;
  endtask

  task automatic start_token(logic [7:0] b);
    int sym;
    sym = -1;
    for (int i = 0; i < 13; i++) begin
      if (sym_chars[i] == b) begin
        sym = i;
      end
    end
    if (blank_byte(b)) begin
      return;
    end else if (letter_byte(b) || b == CHAR_UNDER) begin
      mode = MODE_IDENT;
      tok_begin = offset;
      tok_count = '0;
      word_match = ALL_WORDS;
      narrow(b);
      tok_count = 1;
    end else if (digit_byte(b)) begin
      mode = MODE_NUMBER;
      tok_begin = offset;
      tok_count = 1;
    end else if (b == CHAR_QUOTE) begin
      mode = MODE_STRING;
      tok_begin = bump(offset);
      tok_count = '0;
    end else if (sym >= 0) begin
      add_token(kind_t'(KIND_SYM_FIRST + sym), offset, 1);
    end else if (b == CHAR_HASH) begin
      mode = MODE_COMMENT;
    end else begin
      add_token(KIND_BAD, offset, '0);
      mode = MODE_ERROR;
    end
  endtask

  task automatic scan_request(logic cmd, logic [7:0] b);
    token_t t;
    fresh.delete();
    if (cmd == CMD_END) begin
      if (mode == MODE_STRING) begin
        add_token(KIND_UNTERM, tok_begin, '0);
      end else if (mode != MODE_ERROR) begin
        flush_word();
        add_token(KIND_EOF, offset, '0);
      end
      clear_scan();
    end else begin
      case (mode)
        MODE_IDENT: begin
          if (letter_byte(b) || digit_byte(b) || b == CHAR_UNDER) begin
            narrow(b);
            tok_count = bump(tok_count);
          end else begin
            flush_word();
            start_token(b);
          end
        end
        MODE_NUMBER: begin
          if (digit_byte(b)) begin
            tok_count = bump(tok_count);
          end else begin
            flush_word();
            start_token(b);
          end
        end
        MODE_STRING: begin
          if (b == CHAR_QUOTE) begin
            add_token(KIND_STRING, tok_begin, tok_count);
            mode = MODE_IDLE;
          end else begin
            tok_count = bump(tok_count);
          end
        end
        MODE_COMMENT: begin
          if (b == CHAR_NEWLINE) begin
            mode = MODE_IDLE;
          end
        end
        MODE_ERROR: begin
        end
        default: begin
          start_token(b);
        end
      endcase
      offset = bump(offset);
    end
    for (int i = 0; i < fresh.size(); i++) begin
      t = fresh[i];
      t.last = (i == fresh.size() - 1);
      tokens_due.push_back(t);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    clear_scan();
  end

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      clear_scan();
      tokens_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: token with no request behind it: kind %0d start %0d length %0d",
                   $time, out_token_kind, out_text_start, out_text_length);
          fail_count = fail_count + 1;
        end else begin
          want = tokens_due.pop_front();
          if (out_token_kind !== want.kind) begin
            $display("%0t: token kind expected %0d, got %0d", $time, want.kind,
                     out_token_kind);
            fail_count = fail_count + 1;
          end
          if (out_text_start !== want.start) begin
            $display("%0t: text start expected %0d, got %0d", $time, want.start,
                     out_text_start);
            fail_count = fail_count + 1;
          end
          if (out_text_length !== want.length) begin
            $display("%0t: text length expected %0d, got %0d", $time, want.length,
                     out_text_length);
            fail_count = fail_count + 1;
          end
          if (out_last_result !== want.last) begin
            $display("%0t: last flag expected %0b, got %0b", $time, want.last,
                     out_last_result);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        scan_request(in_cmd, in_char_byte);
      end
    end
    pending = tokens_due.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Top of the script lexer tokenizer bench: clock, reset, source byte streams
// and output back-pressure; the verdict comes from lexer_token_checker.
// Depends on slt_pkg, script_lexer_tokenizer_core and lexer_token_checker.
module testbench;
  import slt_pkg::*;

  localparam int OFFSET_BITS = 24;
  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END = 1'b1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_cmd;
  logic [7:0]             in_char_byte;
  logic                   out_valid;
  logic                   out_ready;
  kind_t                  out_token_kind;
  logic [OFFSET_BITS-1:0] out_text_start;
  logic [OFFSET_BITS-1:0] out_text_length;
  logic                   out_last_result;
  int                     fail_count;
  int                     pending;
  int                     cycles;
  int                     sent_items;
  int                     in_phase_left;
  logic                   in_steady;

  string kw_words [10] = '{"Cmd", "fn", "File", "if", "else", "elif", "while", "loop",
                           "for", "in"};
  string sym_chars = "=(){}[]+-/*.,";
  string word_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";
  string odd_chars = "!$%&':;<>?@\\^`|~";

  // Ident, number, string, comment, keyword ended by a symbol, then a bad
  // byte with input ignored after it, an open string, and an ident cut short
  // by a high byte.
  logic [8:0] warmup [24] = '{
    {CMD_BYTE, CHAR_UNDER}, {CMD_BYTE, "9"}, {CMD_BYTE, CHAR_SPACE}, {CMD_BYTE, "0"},
    {CMD_BYTE, "5"}, {CMD_BYTE, CHAR_QUOTE}, {CMD_BYTE, 8'hFF}, {CMD_BYTE, CHAR_QUOTE},
    {CMD_BYTE, CHAR_HASH}, {CMD_BYTE, 8'h80}, {CMD_BYTE, CHAR_NEWLINE}, {CMD_BYTE, "i"},
    {CMD_BYTE, "f"}, {CMD_BYTE, "("}, {CMD_END, 8'h00},
    {CMD_BYTE, 8'h00}, {CMD_BYTE, "a"}, {CMD_END, 8'hFF},
    {CMD_BYTE, CHAR_QUOTE}, {CMD_BYTE, "x"}, {CMD_END, 8'h00},
    {CMD_BYTE, "a"}, {CMD_BYTE, 8'hFF}, {CMD_END, 8'h55}
  };

  script_lexer_tokenizer_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_char_byte(in_char_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_token_kind(out_token_kind),
    .out_text_start(out_text_start),
    .out_text_length(out_text_length),
    .out_last_result(out_last_result)
  );

  lexer_token_checker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_char_byte(in_char_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_token_kind(out_token_kind),
    .out_text_start(out_text_start),
    .out_text_length(out_text_length),
    .out_last_result(out_last_result),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (in_phase_left == 0) begin
      in_phase_left = $urandom_range(30, 300);
      in_steady = ($urandom_range(0, 2) == 0);
    end
    in_phase_left = in_phase_left - 1;
    r = $urandom_range(0, 99);
    if (in_steady || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] any_but(logic [7:0] c);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while (v == c) begin
      v = 8'($urandom_range(0, 255));
    end
    return v;
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r);
  endfunction

  function automatic logic [7:0] bad_char();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(128, 255));
      1: return odd_chars[$urandom_range(0, odd_chars.len() - 1)];
      2: return 8'($urandom_range(0, 8));
      3: return 8'($urandom_range(14, 31));
      default: return 8'h7F;
    endcase
  endfunction

  task automatic put_byte(logic cmd, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_char_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_items = sent_items + 1;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(CMD_BYTE, s[i]);
    end
  endtask

  task automatic put_token();
    int    r;
    int    n;
    string w;
    r = $urandom_range(0, 99);
    w = kw_words[$urandom_range(0, 9)];
    if (r < 20) begin
      put_text(w);
    end else if (r < 28) begin
      if ($urandom_range(0, 1)) begin
        put_text(w.substr(0, w.len() - 2));
      end else begin
        put_text(w);
        put_byte(CMD_BYTE, word_chars[$urandom_range(0, word_chars.len() - 1)]);
      end
    end else if (r < 40) begin
      n = $urandom_range(0, 52);
      put_byte(CMD_BYTE, word_chars[(n == 52) ? 62 : n]);
      repeat ($urandom_range(0, 7)) begin
        put_byte(CMD_BYTE, word_chars[$urandom_range(0, word_chars.len() - 1)]);
      end
    end else if (r < 52) begin
      repeat ($urandom_range(1, 6)) put_byte(CMD_BYTE, 8'("0" + $urandom_range(0, 9)));
    end else if (r < 60) begin
      put_byte(CMD_BYTE, CHAR_QUOTE);
      repeat ($urandom_range(0, 8)) put_byte(CMD_BYTE, any_but(CHAR_QUOTE));
      put_byte(CMD_BYTE, CHAR_QUOTE);
    end else if (r < 80) begin
      put_byte(CMD_BYTE, sym_chars[$urandom_range(0, 12)]);
    end else if (r < 92) begin
      repeat ($urandom_range(1, 3)) put_byte(CMD_BYTE, blank_char());
    end else begin
      put_byte(CMD_BYTE, CHAR_HASH);
      repeat ($urandom_range(0, 6)) put_byte(CMD_BYTE, any_but(CHAR_NEWLINE));
      put_byte(CMD_BYTE, CHAR_NEWLINE);
    end
  endtask

  task automatic put_stream();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 20)) put_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 30)) begin
        put_token();
        if ($urandom_range(0, 1)) begin
          put_byte(CMD_BYTE, blank_char());
        end
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        put_byte(CMD_BYTE, CHAR_QUOTE);
        repeat ($urandom_range(0, 4)) put_byte(CMD_BYTE, any_but(CHAR_QUOTE));
      end else if (r < 16) begin
        put_byte(CMD_BYTE, bad_char());
        repeat ($urandom_range(0, 3)) put_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
    end
    put_byte(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold = hold - 1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            out_ready = 1'b1;
            hold = $urandom_range(0, 2);
          end
          5: begin
            out_ready = 1'b1;
            hold = $urandom_range(50, 200);
          end
          6, 7, 8: begin
            out_ready = 1'b0;
            hold = $urandom_range(0, 2);
          end
          default: begin
            out_ready = 1'b0;
            hold = $urandom_range(4, 40);
          end
        endcase
      end
    end
  end

  initial begin
    cycles = 0;
    sent_items = 0;
    in_phase_left = 0;
    in_steady = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_BYTE;
    in_char_byte = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (warmup[i]) begin
      put_byte(warmup[i][8], warmup[i][7:0]);
    end
    while (sent_items < ITEM_TARGET) begin
      put_stream();
    end
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
